// ===== hw/rtl/pgs_pkg.sv =====
// Package for the polarized gain scaler: register indexes, mode codes,
// fixed-point constants, reciprocal tables and the pipeline word type.
// No dependencies.
`default_nettype none
package pgs_pkg;

  // Register indexes on the configuration port
  localparam logic REG_KIND  = 1'b0;
  localparam logic REG_STYLE = 1'b1;

  // Polarization kinds
  localparam logic [2:0] KIND_TOTAL = 3'd0;
  localparam logic [2:0] KIND_HORIZ = 3'd1;
  localparam logic [2:0] KIND_VERT  = 3'd2;
  localparam logic [2:0] KIND_LHC   = 3'd3;
  localparam logic [2:0] KIND_RHC   = 3'd4;

  // Scale styles (codes above STYLE_LOG act as linear power)
  localparam logic [2:0] STYLE_LINP = 3'd0;
  localparam logic [2:0] STYLE_LINV = 3'd1;
  localparam logic [2:0] STYLE_ARRL = 3'd2;
  localparam logic [2:0] STYLE_LOG  = 3'd3;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [17:0] DB_PER_OCT_Q16 = 18'd197283;
  localparam logic [15:0] LOSS_FLOOR     = 16'd32768;
  localparam logic [31:0] LN2_Q32        = 32'd2977044472;
  localparam logic signed [23:0] K_LINP_Q24 = 24'sd5573271;
  localparam logic signed [23:0] K_LINV_Q24 = 24'sd2786635;
  localparam logic signed [23:0] K_ARRL_Q24 = 24'sd1410318;
  localparam logic signed [16:0] LOG_FLOOR_Q8 = -17'sd10240;

  // Exact floor division of a 32-bit value by the sine series divisors:
  // q = (x * ceil(2^40 / k)) >> 40
  localparam int SIN_STEPS = 6;
  localparam logic [37:0] SIN_RCP [SIN_STEPS] = '{
    38'(((64'd1 << 40) + 64'd155) / 64'd156),
    38'(((64'd1 << 40) + 64'd109) / 64'd110),
    38'(((64'd1 << 40) + 64'd71) / 64'd72),
    38'(((64'd1 << 40) + 64'd41) / 64'd42),
    38'(((64'd1 << 40) + 64'd19) / 64'd20),
    38'(((64'd1 << 40) + 64'd5) / 64'd6)
  };

  // Exact floor division of a 31-bit value by 11 down to 2:
  // q = (x * ceil(2^35 / k)) >> 35
  localparam int EXP_STEPS = 10;
  localparam logic [34:0] EXP_RCP [EXP_STEPS] = '{
    35'(((64'd1 << 35) + 64'd10) / 64'd11),
    35'(((64'd1 << 35) + 64'd9) / 64'd10),
    35'(((64'd1 << 35) + 64'd8) / 64'd9),
    35'(((64'd1 << 35) + 64'd7) / 64'd8),
    35'(((64'd1 << 35) + 64'd6) / 64'd7),
    35'(((64'd1 << 35) + 64'd5) / 64'd6),
    35'(((64'd1 << 35) + 64'd4) / 64'd5),
    35'(((64'd1 << 35) + 64'd3) / 64'd4),
    35'(((64'd1 << 35) + 64'd2) / 64'd3),
    35'(((64'd1 << 35) + 64'd1) / 64'd2)
  };

  // Divide a 21-bit value by 5: q = (x * ceil(2^24 / 5)) >> 24
  localparam logic [21:0] LOG_RCP = 22'(((64'd1 << 24) + 64'd4) / 64'd5);

  localparam int LOG_BITS = 16;

  // One pipeline word; each stage fills in the fields it owns
  typedef struct packed {
    logic signed [15:0] gain;
    logic signed [15:0] axr;
    logic signed [15:0] tilt;
    logic [30:0] a2;
    logic [30:0] u;
    logic [31:0] x2;
    logic [31:0] h;
    logic [69:0] prod;
    logic [30:0] s;
    logic [30:0] trig;
    logic [32:0] pc;
    logic [32:0] dc;
    logic [32:0] num;
    logic [32:0] den;
    logic        nz;
    logic [5:0]  en;
    logic [5:0]  ed;
    logic [30:0] mn;
    logic [30:0] md;
    logic [15:0] fn;
    logic [15:0] fd;
    logic [39:0] dprod;
    logic signed [15:0] loss;
    logic signed [16:0] g;
    logic signed [40:0] ep;
    logic signed [8:0]  eh;
    logic        neg;
    logic [29:0] y;
    logic        lneg;
    logic [42:0] lp;
    logic [31:0] lograd;
    logic [31:0] radius;
    logic        sat;
  } item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/polarized_gain_scaler_top.sv =====
// Polarization loss and gain-to-radius scaler, fully pipelined.
// Throughput: one word per cycle; every stage holds while the output waits.
// Reset clears the stage valid bits and both configuration registers.
// Uses pgs_pkg for constants, reciprocal tables and the stage word type.
`default_nettype none
module polarized_gain_scaler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: gain_db [15:0], axial_ratio [31:16], tilt_angle [47:32]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  // m_tdata: scaled_radius [31:0], polarization_loss_db [47:32],
  //          radius_saturated [48], zero pad [55:49]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int ST_RED   = 1;
  localparam int ST_SQ    = 2;
  localparam int ST_SIN0  = 3;
  localparam int ST_SINE  = ST_SIN0 + 2 * pgs_pkg::SIN_STEPS;
  localparam int ST_TRIG  = ST_SINE + 1;
  localparam int ST_HVP   = ST_TRIG + 1;
  localparam int ST_SEL   = ST_HVP + 1;
  localparam int ST_MSB   = ST_SEL + 1;
  localparam int ST_NORM  = ST_MSB + 1;
  localparam int ST_LOG0  = ST_NORM + 1;
  localparam int ST_DIFF  = ST_LOG0 + pgs_pkg::LOG_BITS;
  localparam int ST_LOSS  = ST_DIFF + 1;
  localparam int ST_GAIN  = ST_LOSS + 1;
  localparam int ST_FRAC  = ST_GAIN + 1;
  localparam int ST_EXP0  = ST_FRAC + 1;
  localparam int ST_EXPL  = ST_EXP0 + 2 * pgs_pkg::EXP_STEPS;
  localparam int ST_OUT   = ST_EXPL + 1;
  localparam int NST      = ST_OUT + 1;

  logic [2:0] kind;
  logic [2:0] style;
  logic       adv;
  logic [NST-1:0] v;
  pgs_pkg::item_t st [NST];
  pgs_pkg::item_t nx [NST];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= pgs_pkg::KIND_TOTAL;
      style <= pgs_pkg::STYLE_LINP;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == pgs_pkg::REG_KIND) begin
        kind <= pwdata[2:0];
      end else begin
        style <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pgs_pkg::REG_STYLE) begin
      prdata = {29'd0, style};
    end else begin
      prdata = {29'd0, kind};
    end
  end

  // ---------------- pipeline control ----------------
  assign adv      = !v[NST-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[NST-1];
  assign m_tdata  = {7'd0, st[NST-1].sat, st[NST-1].loss, st[NST-1].radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  function automatic logic [5:0] msb_idx(input logic [32:0] x);
    logic [5:0] e;
    e = '0;
    for (int i = 1; i < 33; i++) begin
      if (x[i]) e = 6'(i);
    end
    return e;
  endfunction

  function automatic logic [30:0] norm_q30(input logic [32:0] x, input logic [5:0] e);
    logic [63:0] w;
    if (e >= 6'd30) begin
      w = 64'(x) >> (e - 6'd30);
    end else begin
      w = 64'(x) << (6'd30 - e);
    end
    return w[30:0];
  endfunction

  // ---------------- input and angle reduction ----------------
  always_comb begin
    nx[0]      = '0;
    nx[0].gain = s_tdata[15:0];
    nx[0].axr  = s_tdata[31:16];
    nx[0].tilt = s_tdata[47:32];
  end

  always_comb begin
    logic signed [34:0] t;
    logic signed [34:0] tr;
    logic signed [31:0] sq;
    nx[ST_RED] = st[ST_RED-1];
    t  = {{2{st[ST_RED-1].tilt[15]}}, st[ST_RED-1].tilt, 17'd0};
    sq = 32'(st[ST_RED-1].axr) * 32'(st[ST_RED-1].axr);
    priority if (t > pgs_pkg::HALF_PI_Q30) begin
      tr = t - pgs_pkg::PI_Q30;
    end else if (t < -pgs_pkg::HALF_PI_Q30) begin
      tr = t + pgs_pkg::PI_Q30;
    end else begin
      tr = t;
    end
    nx[ST_RED].a2 = sq[30:0];
    nx[ST_RED].u  = tr[34] ? 31'(-tr) : tr[30:0];
  end

  always_comb begin
    logic [61:0] uu;
    logic signed [17:0] pp;
    logic [33:0] p2;
    nx[ST_SQ] = st[ST_SQ-1];
    uu = 62'(st[ST_SQ-1].u) * 62'(st[ST_SQ-1].u);
    if (kind == pgs_pkg::KIND_LHC) begin
      pp = 18'sd32768 + 18'(st[ST_SQ-1].axr);
    end else begin
      pp = 18'sd32768 - 18'(st[ST_SQ-1].axr);
    end
    p2 = 34'(pp[16:0]) * 34'(pp[16:0]);
    nx[ST_SQ].x2 = uu[61:30];
    nx[ST_SQ].h  = pgs_pkg::ONE_Q30;
    nx[ST_SQ].pc = p2[32:0];
    nx[ST_SQ].dc = (33'(st[ST_SQ-1].a2) + 33'(pgs_pkg::ONE_Q30)) << 1;
  end

  // ---------------- sine series, two stages per term ----------------
  for (genvar j = 0; j < pgs_pkg::SIN_STEPS; j++) begin : g_sin
    localparam int SA = ST_SIN0 + 2 * j;
    always_comb begin
      nx[SA]      = st[SA-1];
      nx[SA].prod = 70'(st[SA-1].x2) * 70'(st[SA-1].h);
    end
    always_comb begin
      logic [69:0] q;
      nx[SA+1] = st[SA];
      q = 70'(st[SA].prod[61:30]) * 70'(pgs_pkg::SIN_RCP[j]);
      nx[SA+1].h = pgs_pkg::ONE_Q30 - q[71-2:40];
    end
  end

  always_comb begin
    logic [61:0] p;
    nx[ST_SINE] = st[ST_SINE-1];
    p = 62'(st[ST_SINE-1].u) * 62'(st[ST_SINE-1].h);
    // clip sin to one
    if (p[61:30] > pgs_pkg::ONE_Q30) begin
      nx[ST_SINE].s = pgs_pkg::ONE_Q30[30:0];
    end else begin
      nx[ST_SINE].s = p[60:30];
    end
  end

  always_comb begin
    logic [61:0] p;
    nx[ST_TRIG] = st[ST_TRIG-1];
    p = 62'(st[ST_TRIG-1].s) * 62'(st[ST_TRIG-1].s);
    if (kind == pgs_pkg::KIND_VERT) begin
      nx[ST_TRIG].trig = pgs_pkg::ONE_Q30[30:0] - p[60:30];
    end else begin
      nx[ST_TRIG].trig = p[60:30];
    end
  end

  always_comb begin
    nx[ST_HVP] = st[ST_HVP-1];
    nx[ST_HVP].prod = 70'(pgs_pkg::ONE_Q30[30:0] - st[ST_HVP-1].a2)
                    * 70'(st[ST_HVP-1].trig);
  end

  always_comb begin
    nx[ST_SEL] = st[ST_SEL-1];
    if (kind == pgs_pkg::KIND_HORIZ || kind == pgs_pkg::KIND_VERT) begin
      nx[ST_SEL].num = 33'(st[ST_SEL-1].a2) + 33'(st[ST_SEL-1].prod[61:30]);
      nx[ST_SEL].den = 33'(st[ST_SEL-1].a2) + 33'(pgs_pkg::ONE_Q30);
    end else if (kind == pgs_pkg::KIND_LHC || kind == pgs_pkg::KIND_RHC) begin
      nx[ST_SEL].num = st[ST_SEL-1].pc;
      nx[ST_SEL].den = st[ST_SEL-1].dc;
    end else begin
      nx[ST_SEL].num = 33'(pgs_pkg::ONE_Q30);
      nx[ST_SEL].den = 33'(pgs_pkg::ONE_Q30);
    end
    nx[ST_SEL].nz = (nx[ST_SEL].num != '0);
  end

  // ---------------- log2 of numerator and denominator ----------------
  always_comb begin
    nx[ST_MSB]    = st[ST_MSB-1];
    nx[ST_MSB].en = msb_idx(st[ST_MSB-1].num);
    nx[ST_MSB].ed = msb_idx(st[ST_MSB-1].den);
  end

  always_comb begin
    nx[ST_NORM]    = st[ST_NORM-1];
    nx[ST_NORM].mn = norm_q30(st[ST_NORM-1].num, st[ST_NORM-1].en);
    nx[ST_NORM].md = norm_q30(st[ST_NORM-1].den, st[ST_NORM-1].ed);
    nx[ST_NORM].fn = '0;
    nx[ST_NORM].fd = '0;
  end

  for (genvar j = 0; j < pgs_pkg::LOG_BITS; j++) begin : g_log
    localparam int SL = ST_LOG0 + j;
    always_comb begin
      logic [61:0] qn;
      logic [61:0] qd;
      nx[SL] = st[SL-1];
      qn = 62'(st[SL-1].mn) * 62'(st[SL-1].mn);
      qd = 62'(st[SL-1].md) * 62'(st[SL-1].md);
      // square, then halve and emit a one when the mantissa reaches two
      if (qn[61]) begin
        nx[SL].mn = qn[61:31];
        nx[SL].fn = {st[SL-1].fn[14:0], 1'b1};
      end else begin
        nx[SL].mn = qn[60:30];
        nx[SL].fn = {st[SL-1].fn[14:0], 1'b0};
      end
      if (qd[61]) begin
        nx[SL].md = qd[61:31];
        nx[SL].fd = {st[SL-1].fd[14:0], 1'b1};
      end else begin
        nx[SL].md = qd[60:30];
        nx[SL].fd = {st[SL-1].fd[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [21:0] ln;
    logic [21:0] ld;
    logic [21:0] d;
    nx[ST_DIFF] = st[ST_DIFF-1];
    ln = {st[ST_DIFF-1].en, st[ST_DIFF-1].fn};
    ld = {st[ST_DIFF-1].ed, st[ST_DIFF-1].fd};
    d  = (ld > ln) ? (ld - ln) : '0;
    nx[ST_DIFF].dprod = 40'(d) * 40'(pgs_pkg::DB_PER_OCT_Q16) + (40'd1 << 23);
  end

  always_comb begin
    logic [15:0] dd;
    nx[ST_LOSS] = st[ST_LOSS-1];
    dd = st[ST_LOSS-1].dprod[39:24];
    if (dd > pgs_pkg::LOSS_FLOOR) dd = pgs_pkg::LOSS_FLOOR;
    if (kind != pgs_pkg::KIND_HORIZ && kind != pgs_pkg::KIND_VERT &&
        kind != pgs_pkg::KIND_LHC && kind != pgs_pkg::KIND_RHC) begin
      nx[ST_LOSS].loss = '0;
    end else if (!st[ST_LOSS-1].nz) begin
      nx[ST_LOSS].loss = 16'(-$signed({1'b0, pgs_pkg::LOSS_FLOOR}));
    end else begin
      nx[ST_LOSS].loss = 16'(-$signed({1'b0, dd}));
    end
  end

  // ---------------- gain sum and exponent ----------------
  always_comb begin
    logic signed [16:0] g;
    logic signed [23:0] k;
    nx[ST_GAIN] = st[ST_GAIN-1];
    g = 17'(st[ST_GAIN-1].gain) + 17'(st[ST_GAIN-1].loss);
    unique case (style)
      pgs_pkg::STYLE_LINV: k = pgs_pkg::K_LINV_Q24;
      pgs_pkg::STYLE_ARRL: k = pgs_pkg::K_ARRL_Q24;
      default:             k = pgs_pkg::K_LINP_Q24;
    endcase
    nx[ST_GAIN].g  = g;
    nx[ST_GAIN].ep = 41'(g) * 41'(k);
  end

  always_comb begin
    logic [63:0] fy;
    logic signed [16:0] gx;
    logic [23:0] lx;
    nx[ST_FRAC] = st[ST_FRAC-1];
    fy = 64'(st[ST_FRAC-1].ep[31:0]) * 64'(pgs_pkg::LN2_Q32);
    nx[ST_FRAC].y   = fy[63:34];
    nx[ST_FRAC].eh  = st[ST_FRAC-1].ep[40:32];
    nx[ST_FRAC].neg = ($signed(st[ST_FRAC-1].ep[40:32]) < -9'sd128);
    nx[ST_FRAC].h   = pgs_pkg::ONE_Q30;
    // log style: ((g + 40 dB) * 256 + 20) / 40, as /8 then /5
    gx = st[ST_FRAC-1].g - pgs_pkg::LOG_FLOOR_Q8;
    lx = {gx[15:0], 8'd0} + 24'd20;
    nx[ST_FRAC].lneg = (st[ST_FRAC-1].g < pgs_pkg::LOG_FLOOR_Q8);
    nx[ST_FRAC].lp   = 43'(lx[23:3]) * 43'(pgs_pkg::LOG_RCP);
  end

  // ---------------- exponential series, k = 11 down to 2 ----------------
  for (genvar j = 0; j < pgs_pkg::EXP_STEPS; j++) begin : g_exp
    localparam int SE = ST_EXP0 + 2 * j;
    always_comb begin
      nx[SE]      = st[SE-1];
      nx[SE].prod = 70'(st[SE-1].y) * 70'(st[SE-1].h);
    end
    always_comb begin
      logic [69:0] q;
      nx[SE+1] = st[SE];
      q = 70'(st[SE].prod[60:30]) * 70'(pgs_pkg::EXP_RCP[j]);
      nx[SE+1].h = pgs_pkg::ONE_Q30 + q[66:35];
    end
  end

  always_comb begin
    logic [61:0] p;
    nx[ST_EXPL] = st[ST_EXPL-1];
    p = 62'(st[ST_EXPL-1].y) * 62'(st[ST_EXPL-1].h);
    nx[ST_EXPL].h = pgs_pkg::ONE_Q30 + p[61:30];
    nx[ST_EXPL].lograd = st[ST_EXPL-1].lneg ? '0 : 32'(st[ST_EXPL-1].lp[42:24]);
  end

  // ---------------- scale by the integer exponent, saturate ----------------
  always_comb begin
    logic signed [9:0] sh;
    logic [9:0]  n;
    logic [32:0] vl;
    logic [63:0] r;
    nx[ST_OUT] = st[ST_OUT-1];
    nx[ST_OUT].radius = '0;
    nx[ST_OUT].sat    = 1'b0;
    sh = 10'(st[ST_OUT-1].eh) - 10'sd14;
    n  = 10'(-sh);
    vl = 33'(st[ST_OUT-1].h) << sh[0];
    r  = (64'(st[ST_OUT-1].h) + (64'd1 << (n - 10'd1))) >> n;
    priority if (style == pgs_pkg::STYLE_LOG) begin
      nx[ST_OUT].radius = st[ST_OUT-1].lograd;
    end else if (st[ST_OUT-1].neg) begin
      nx[ST_OUT].radius = '0;
    end else if (sh >= 10'sd2) begin
      nx[ST_OUT].radius = '1;
      nx[ST_OUT].sat    = 1'b1;
    end else if (sh >= 10'sd0) begin
      if (vl[32]) begin
        nx[ST_OUT].radius = '1;
        nx[ST_OUT].sat    = 1'b1;
      end else begin
        nx[ST_OUT].radius = vl[31:0];
      end
    end else if (n >= 10'd40) begin
      nx[ST_OUT].radius = '0;
    end else begin
      nx[ST_OUT].radius = r[31:0];
    end
  end

  // ---------------- checks ----------------
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[48] |-> m_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("saturated word without full-scale radius");

  a_loss_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47] || m_tdata[47:32] == 16'd0)
    else $error("positive polarization loss");

  a_log_nosat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && style == pgs_pkg::STYLE_LOG |-> !m_tdata[48])
    else $error("saturation flagged in log style");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input held off without an output stall");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for polarized_gain_scaler_top: drives sample words and APB register
// writes, predicts each result with an integer model of the scaler and checks it.
// Depends on pgs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 62;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ADDR_KIND  = 3'd0;
  localparam logic [2:0] ADDR_STYLE = 3'd4;

  // Hold the expected result words (radius, loss, saturation flag) and compare each output against the oldest one
  class radius_scoreboard;
    logic [2:0] kind;
    logic [2:0] style;
    logic [48:0] pending[$];
    int errors;
    int checked;

    function new();
      kind = pgs_pkg::KIND_TOTAL;
      style = pgs_pkg::STYLE_LINP;
      errors = 0;
      checked = 0;
    endfunction

    function longint unsigned sin_sq(logic signed [15:0] tilt);
      longint t;
      longint unsigned u, x2, h, s;
      int unsigned divs[6];
      divs = '{156, 110, 72, 42, 20, 6};
      t = longint'(tilt) * 131072;
      while (t > longint'(pgs_pkg::HALF_PI_Q30)) t -= longint'(pgs_pkg::PI_Q30);
      while (t < -longint'(pgs_pkg::HALF_PI_Q30)) t += longint'(pgs_pkg::PI_Q30);
      u = (t < 0) ? -t : t;
      x2 = (u * u) >> 30;
      h = 64'd1 << 30;
      for (int i = 0; i < 6; i++) h = (64'd1 << 30) - ((x2 * h) >> 30) / divs[i];
      s = (u * h) >> 30;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      return (s * s) >> 30;
    endfunction

    function longint unsigned log2_fix(longint unsigned v);
      int e;
      longint unsigned t, m;
      longint unsigned frac;
      e = 0;
      t = v;
      frac = 0;
      while (t > 1) begin
        t >>= 1;
        e++;
      end
      m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (64'd1 << 31)) begin
          m >>= 1;
          frac |= 1;
        end
      end
      return longint'(e) * 65536 + frac;
    endfunction

    function int polar_loss(logic signed [15:0] a, logic signed [15:0] tilt);
      longint unsigned a2, num, den, trig, d, ln, ld;
      longint p;
      a2 = longint'(a) * longint'(a);
      case (kind)
        pgs_pkg::KIND_HORIZ, pgs_pkg::KIND_VERT: begin
          trig = sin_sq(tilt);
          if (kind == pgs_pkg::KIND_VERT) trig = (64'd1 << 30) - trig;
          num = a2 + ((((64'd1 << 30) - a2) * trig) >> 30);
          den = (64'd1 << 30) + a2;
        end
        pgs_pkg::KIND_LHC, pgs_pkg::KIND_RHC: begin
          p = (kind == pgs_pkg::KIND_LHC) ? 32768 + longint'(a) : 32768 - longint'(a);
          num = p * p;
          den = 2 * ((64'd1 << 30) + a2);
        end
        default: return 0;
      endcase
      if (num == 0) return -32768;
      ln = log2_fix(num);
      ld = log2_fix(den);
      d = (ld > ln) ? ld - ln : 0;
      d = (d * 197283 + (64'd1 << 23)) >> 24;
      if (d > 32768) d = 32768;
      return -int'(d);
    endfunction

    function longint unsigned exp_radius(int g, longint k, output bit sat);
      longint e, sh;
      longint unsigned ue, f, y, h, v;
      sat = 0;
      e = longint'(g) * k + (longint'(128) << 32);
      if (e < 0) return 0;
      ue = e;
      f = ue & 64'hFFFF_FFFF;
      sh = longint'(ue >> 32) - 142;
      y = (f * 64'd2977044472) >> 34;
      h = 64'd1 << 30;
      for (int i = 11; i >= 1; i--) h = (64'd1 << 30) + ((y * h) >> 30) / i;
      if (sh >= 2) begin
        sat = 1;
        return 64'hFFFF_FFFF;
      end
      if (sh >= 0) begin
        v = h << sh;
        if (v > 64'hFFFF_FFFF) begin
          sat = 1;
          return 64'hFFFF_FFFF;
        end
        return v;
      end
      if (-sh >= 40) return 0;
      return (h + (64'd1 << (-sh - 1))) >> (-sh);
    endfunction

    function void note_sample(logic [47:0] word);
      int loss, g;
      longint unsigned radius;
      bit sat;
      loss = polar_loss(word[31:16], word[47:32]);
      g = int'($signed(word[15:0])) + loss;
      sat = 0;
      case (style)
        pgs_pkg::STYLE_LINV: radius = exp_radius(g, pgs_pkg::K_LINV_Q24, sat);
        pgs_pkg::STYLE_ARRL: radius = exp_radius(g, pgs_pkg::K_ARRL_Q24, sat);
        pgs_pkg::STYLE_LOG:
          radius = (g < -10240) ? 0 : (longint'(g + 10240) * 256 + 20) / 40;
        default: radius = exp_radius(g, pgs_pkg::K_LINP_Q24, sat);
      endcase
      pending.push_back({sat, 16'(loss), radius[31:0]});
    endfunction

    task check_result(logic [55:0] word);
      logic [48:0] exp_word;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 49'd0, word[48:0]);
        return;
      end
      exp_word = pending.pop_front();
      checked++;
      if (word[31:0] !== exp_word[31:0])
        report_mismatch("scaled_radius", 49'(exp_word[31:0]), 49'(word[31:0]));
      if (word[47:32] !== exp_word[47:32])
        report_mismatch("polarization_loss_db", 49'(exp_word[47:32]), 49'(word[47:32]));
      if (word[48] !== exp_word[48])
        report_mismatch("radius_saturated", 49'(exp_word[48]), 49'(word[48]));
    endtask

    task report_mismatch(string what, logic [48:0] want, logic [48:0] got);
      errors++;
      if (errors <= 40)
        $display("MISMATCH %s: expected %0h got %0h (kind %0d style %0d)",
                 what, want, got, kind, style);
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [55:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  radius_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int samples_sent;
  int quiet_cycles;

  polarized_gain_scaler_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    samples_sent = 0;
  end

  // Receiver: stall at random, or hold off entirely on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Watchdog: count cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results pending", sb.pending.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_KIND) sb.kind = value[2:0];
    else if (addr == ADDR_STYLE) sb.style = value[2:0];
  endtask

  task automatic configure(input logic [2:0] kind, input logic [2:0] style);
    reg_write(ADDR_KIND, {29'd0, kind});
    reg_write(ADDR_STYLE, {29'd0, style});
  endtask

  // Offer one word, idling first at the current rate, and hold until accepted;
  // the valid stays up so that the next word can follow without a gap
  task automatic send_sample(input logic [15:0] gain, input logic [15:0] axr,
                             input logic [15:0] tilt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tilt, axr, gain};
    do @(posedge clk); while (!s_tready);
    sb.note_sample({tilt, axr, gain});
    samples_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_sample();
    logic [15:0] gain, axr, tilt;
    gain = 16'($urandom);
    case ($urandom_range(3))
      0: gain = 16'($signed($urandom_range(0, 16000)) - 8000);
      1: gain = 16'($signed($urandom_range(0, 1200)) - 600);
      default: ;
    endcase
    axr = 16'($urandom);
    tilt = ($urandom_range(9) == 0) ? 16'($urandom)
                                    : 16'($signed($urandom_range(0, 51472)) - 25736);
    send_sample(gain, axr, tilt);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    recv_stall_pct = 0;

    // Directed: every kind and style, field extremes, zero factor, clamp, saturation
    for (int p = 0; p < 5; p++) begin
      configure(3'(p), 3'(p % 4));
      send_sample(16'h7FFF, 16'h8000, 16'h6488);
      send_sample(16'h8000, 16'h7FFF, 16'h9B78);
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'hD800, 16'h8000, 16'h3244);
      send_sample(16'h0C00, 16'h0001, 16'h7FFF);
      drain();
    end

    // Random phases, each with its own settings and idling mix
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 0) configure(3'd7, 3'd7);
      else if (ph == 1) configure(3'd5, 3'd4);
      else configure(3'($urandom_range(7)), 3'($urandom_range(7)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (ph == 4) begin
        // Back-pressure: block the output long enough for the pipeline to fill
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
          repeat (100) random_sample();
        join
      end else begin
        repeat (35) random_sample();
      end
      drain();
    end

    $display("Covered %0d samples over all polarization kinds and scale styles,",
             samples_sent);
    $display("with idle, stall and back-pressure phases; %0d results checked.",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
